@@ sv/orss_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the 1-Wire ROM search unit.
package orss_pkg;

  typedef enum logic [2:0] {
    REQ_FIRST  = 3'd0,
    REQ_NEXT   = 3'd1,
    REQ_VERIFY = 3'd2,
    REQ_TARGET = 3'd3,
    REQ_SKIP   = 3'd4,
    REQ_BIT    = 3'd5
  } req_e;

  typedef enum logic [2:0] {
    KIND_CMD   = 3'd0,
    KIND_DIR   = 3'd1,
    KIND_FIN   = 3'd2,
    KIND_SETUP = 3'd3,
    KIND_IGN   = 3'd4
  } kind_e;

  // Discrepancy value that forces the search to follow the stored ROM.
  localparam logic [6:0] DiscAll    = 7'd64;
  // Bit position after the sixty-fourth bit.
  localparam logic [6:0] RomEnd     = 7'd65;
  // Positions below this lie in the family byte.
  localparam logic [6:0] FamLimit   = 7'd9;
  // Reflected Dallas CRC-8 polynomial.
  localparam logic [7:0] CrcPoly    = 8'h8C;

  typedef struct packed {
    logic [2:0] req_type;
    logic       bus_level;
    logic       id_bit;
    logic       cmp_bit;
    logic [7:0] fam_byte;
  } req_t;

  typedef struct packed {
    logic [2:0]  out_kind;
    logic        direction_bit;
    logic        found;
    logic [63:0] rom_number;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [63:0] rom_id;
    logic [6:0]  last_disc;
    logic        last_dev;
    logic [3:0]  last_fam;
    logic [6:0]  bit_pos;
    logic [6:0]  zero_pos;
    logic [7:0]  crc;
    logic        searching;
    logic        verifying;
  } state_t;

  typedef struct packed {
    logic [63:0] rom;
    logic [6:0]  disc;
    logic        dev;
    logic [3:0]  fam;
  } saved_t;

endpackage

@@ sv/orss_step.sv @@
`timescale 1ns / 1ps
// Combinational next-state and result logic for one search item.
module orss_step (
  input  orss_pkg::req_t   req_i,
  input  orss_pkg::state_t cur_i,
  input  orss_pkg::saved_t sav_i,
  output orss_pkg::state_t nxt_o,
  output orss_pkg::saved_t sav_o,
  output orss_pkg::res_t   res0_o,
  output orss_pkg::res_t   res1_o,
  output logic             two_o
);

  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] v);
    logic [7:0] c;
    c = crc ^ v;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ orss_pkg::CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  orss_pkg::state_t nxt;
  orss_pkg::saved_t sav;
  orss_pkg::res_t   r0;
  orss_pkg::res_t   r1;
  orss_pkg::res_t   fin;
  logic             two;
  logic             do_fin;
  logic             do_start;
  logic             fin_ok;
  logic             dir;
  logic [5:0]       idx;

  always_comb begin
    nxt      = cur_i;
    sav      = sav_i;
    two      = 1'b0;
    do_fin   = 1'b0;
    do_start = 1'b0;
    fin_ok   = 1'b0;
    dir      = 1'b0;
    idx      = 6'(cur_i.bit_pos - 7'd1);
    r0       = '{out_kind: orss_pkg::KIND_IGN, direction_bit: 1'b0, found: 1'b0,
                 rom_number: cur_i.rom_id, last: 1'b1};
    r1       = r0;
    fin      = r0;

    if (cur_i.searching) begin
      if (req_i.req_type != orss_pkg::REQ_BIT) begin
        r0.out_kind = orss_pkg::KIND_IGN;
      end else if (req_i.id_bit && req_i.cmp_bit) begin
        // Nobody answered in this slot.
        do_fin = 1'b1;
      end else begin
        if (req_i.id_bit != req_i.cmp_bit) begin
          dir = req_i.id_bit;
        end else begin
          if (cur_i.bit_pos < cur_i.last_disc) begin
            dir = cur_i.rom_id[idx];
          end else begin
            dir = (cur_i.bit_pos == cur_i.last_disc);
          end
          if (!dir) begin
            nxt.zero_pos = cur_i.bit_pos;
            if (cur_i.bit_pos < orss_pkg::FamLimit) begin
              nxt.last_fam = cur_i.bit_pos[3:0];
            end
          end
        end
        nxt.rom_id[idx] = dir;
        nxt.bit_pos     = cur_i.bit_pos + 7'd1;
        if (idx[2:0] == 3'd7) begin
          nxt.crc = crc_byte(cur_i.crc, nxt.rom_id[{idx[5:3], 3'b000} +: 8]);
        end
        r0.out_kind      = orss_pkg::KIND_DIR;
        r0.direction_bit = dir;
        r0.rom_number    = nxt.rom_id;
        if (nxt.bit_pos >= orss_pkg::RomEnd) begin
          two     = 1'b1;
          do_fin  = 1'b1;
          fin_ok  = (nxt.crc == 8'd0);
          r0.last = 1'b0;
        end
      end
    end else begin
      case (req_i.req_type)
        orss_pkg::REQ_FIRST: begin
          nxt.last_disc = '0;
          nxt.last_dev  = 1'b0;
          nxt.last_fam  = '0;
          do_start      = 1'b1;
        end
        orss_pkg::REQ_NEXT: begin
          do_start = 1'b1;
        end
        orss_pkg::REQ_VERIFY: begin
          sav.rom       = cur_i.rom_id;
          sav.disc      = cur_i.last_disc;
          sav.dev       = cur_i.last_dev;
          sav.fam       = cur_i.last_fam;
          nxt.last_disc = orss_pkg::DiscAll;
          nxt.last_dev  = 1'b0;
          nxt.verifying = 1'b1;
          do_start      = 1'b1;
        end
        orss_pkg::REQ_TARGET: begin
          nxt.rom_id    = {56'd0, req_i.fam_byte};
          nxt.last_disc = orss_pkg::DiscAll;
          nxt.last_fam  = '0;
          nxt.last_dev  = 1'b0;
          r0.out_kind   = orss_pkg::KIND_SETUP;
          r0.rom_number = nxt.rom_id;
        end
        orss_pkg::REQ_SKIP: begin
          nxt.last_disc = {3'd0, cur_i.last_fam};
          nxt.last_fam  = '0;
          if (cur_i.last_fam == 4'd0) begin
            nxt.last_dev = 1'b1;
          end
          r0.out_kind = orss_pkg::KIND_SETUP;
        end
        default: begin
          r0.out_kind = orss_pkg::KIND_IGN;
        end
      endcase
    end

    if (do_start) begin
      nxt.bit_pos  = 7'd1;
      nxt.zero_pos = '0;
      nxt.crc      = '0;
      if (nxt.last_dev) begin
        do_fin = 1'b1;
      end else if (!req_i.bus_level) begin
        nxt.last_disc = '0;
        nxt.last_dev  = 1'b0;
        nxt.last_fam  = '0;
        do_fin        = 1'b1;
      end else begin
        nxt.searching = 1'b1;
        r0.out_kind   = orss_pkg::KIND_CMD;
        r0.rom_number = nxt.rom_id;
      end
    end

    if (do_fin) begin
      if (fin_ok) begin
        nxt.last_disc = nxt.zero_pos;
        if (nxt.zero_pos == 7'd0) begin
          nxt.last_dev = 1'b1;
        end
      end
      // A bad CRC or an empty family byte counts as a failed search.
      if (!fin_ok || nxt.rom_id[7:0] == 8'd0) begin
        nxt.last_disc = '0;
        nxt.last_dev  = 1'b0;
        nxt.last_fam  = '0;
        fin_ok        = 1'b0;
      end
      if (nxt.verifying) begin
        fin_ok        = fin_ok && (nxt.rom_id == sav.rom);
        nxt.rom_id    = sav.rom;
        nxt.last_disc = sav.disc;
        nxt.last_dev  = sav.dev;
        nxt.last_fam  = sav.fam;
      end
      nxt.searching = 1'b0;
      nxt.verifying = 1'b0;
      fin = '{out_kind: orss_pkg::KIND_FIN, direction_bit: 1'b0, found: fin_ok,
              rom_number: nxt.rom_id, last: 1'b1};
      if (two) begin
        r1 = fin;
      end else begin
        r0 = fin;
      end
    end
  end

  assign nxt_o  = nxt;
  assign sav_o  = sav;
  assign res0_o = r0;
  assign res1_o = r1;
  assign two_o  = two;

endmodule

@@ sv/orss_res_fifo.sv @@
`timescale 1ns / 1ps
// Result queue that takes one or two items per cycle and gives one.
module orss_res_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  logic           push2_i,
  input  orss_pkg::res_t data0_i,
  input  orss_pkg::res_t data1_i,
  input  logic           pop_i,
  output logic           room_o,
  output logic           valid_o,
  output orss_pkg::res_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  orss_pkg::res_t  mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d, wr_nx;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign wr_nx = ptr_inc(wr_q);

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    if (push2_i) begin
      wr_d = ptr_inc(wr_nx);
    end else if (push_i) begin
      wr_d = wr_nx;
    end
    if (pop_i) begin
      rd_d = ptr_inc(rd_q);
    end
    cnt_d = cnt_q + CntW'(push_i) + CntW'(push2_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data0_i;
    end
    if (push2_i) begin
      mem_q[wr_nx] <= data1_i;
    end
  end

  // Room is kept for a full pair so that a finishing bit never overflows.
  assign room_o  = (cnt_q <= CntW'(Depth - 2));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

endmodule

@@ sv/onewire_rom_search_unit.sv @@
`timescale 1ns / 1ps
// 1-Wire ROM search unit: request and bit-pair items in, bus actions and results out.
//
// The input channel carries one request item per handshake: a search command
// (first, next, verify), a family setup (target, skip) or, while a search runs,
// one id/complement bit pair. The output channel returns one result item per
// request, or two for the sixty-fourth bit pair (the direction bit and then the
// finish item); the last result of each request has last set.
// An accepted item sits in the input register while the step logic works it;
// its results are written into a result queue of ResDepth entries once the
// queue has room for a pair, and the input register is then free for the next item.
// Throughput is one item per cycle while the queue has room for a pair; it is set
// by the combinational step logic and by the queue, which must hold room for a
// pair of results before an item is worked.
// Reset clears the search state: ROM number zero, no discrepancy, bit position
// one, no search running, and empties the queue.
// When the receiver stalls, the head result holds and the queue fills; once it
// has no room for a pair the input register holds its item and the input
// stall is raised.
module onewire_rom_search_unit #(
  parameter int unsigned ResDepth = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  orss_pkg::req_t in_item_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output orss_pkg::res_t out_item_o
);

  logic             in_vld_q, in_vld_d;
  orss_pkg::req_t   in_item_q;
  orss_pkg::state_t state_q, state_d;
  orss_pkg::saved_t saved_q, saved_d;
  orss_pkg::res_t   res0, res1;
  logic             step_two;
  logic             room;
  logic             proceed;
  logic             in_take;
  logic             pop;

  assign proceed    = in_vld_q && room;
  assign in_stall_o = in_vld_q && !room;
  assign in_take    = in_valid_i && !in_stall_o;
  assign in_vld_d   = in_take || (in_vld_q && !proceed);
  assign pop        = out_valid_o && !out_stall_i;

  orss_step u_step (
    .req_i  (in_item_q),
    .cur_i  (state_q),
    .sav_i  (saved_q),
    .nxt_o  (state_d),
    .sav_o  (saved_d),
    .res0_o (res0),
    .res1_o (res1),
    .two_o  (step_two)
  );

  orss_res_fifo #(
    .Depth (ResDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (proceed),
    .push2_i (proceed && step_two),
    .data0_i (res0),
    .data1_i (res1),
    .pop_i   (pop),
    .room_o  (room),
    .valid_o (out_valid_o),
    .head_o  (out_item_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      state_q  <= '{rom_id: '0, last_disc: '0, last_dev: 1'b0, last_fam: '0,
                   bit_pos: 7'd1, zero_pos: '0, crc: '0, searching: 1'b0,
                   verifying: 1'b0};
    end else begin
      in_vld_q <= in_vld_d;
      if (proceed) begin
        state_q <= state_d;
      end
    end
  end

  // Saved copies are always written at a verify start before they are read.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= in_item_i;
    end
    if (proceed) begin
      saved_q <= saved_d;
    end
  end

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proceed && step_two) |->
      (res0.out_kind == orss_pkg::KIND_DIR && !res0.last &&
       res1.out_kind == orss_pkg::KIND_FIN && res1.last))
    else $error("two-result item is not a direction bit followed by finish");

  a_fin_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proceed && ((res0.out_kind == orss_pkg::KIND_FIN) || step_two)) |=>
      (!state_q.searching && !state_q.verifying))
    else $error("search still running after a finish item");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.bit_pos >= 7'd1) && (state_q.bit_pos <= orss_pkg::RomEnd))
    else $error("bit position out of range");

  a_verify_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.verifying |-> state_q.searching)
    else $error("verify flag set without a running search");

endmodule

@@ dv/onewire_rom_search_unit_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the 1-Wire ROM search unit with simulated bus devices.
module onewire_rom_search_unit_test;

  // Request codes that the package leaves unnamed; the unit ignores them.
  localparam logic [2:0] ReqSpareA   = 3'd6;
  localparam logic [2:0] ReqSpareB   = 3'd7;
  localparam int         RandomItems = 900;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  orss_pkg::req_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  orss_pkg::res_t out_item;

  bit in_quiet = 1'b0;
  bit out_quiet = 1'b0;
  logic [63:0] population[$];

  onewire_rom_search_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [7:0] dallas_crc_step(logic [7:0] acc, logic [7:0] data);
    logic [7:0] c;
    c = acc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ orss_pkg::CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  class rom_search_tracker;
    logic [63:0] rom, saved_rom;
    logic [6:0]  disc, saved_disc, bit_pos, zero_pos;
    logic [3:0]  fam_disc, saved_fam;
    logic        dev, saved_dev, searching, verifying;
    logic [7:0]  crc;
    logic        dir_taken;
    orss_pkg::res_t results_due[$];
    int          mismatches;
    int          accepted;

    function new();
      rom = '0;
      saved_rom = '0;
      disc = '0;
      saved_disc = '0;
      zero_pos = '0;
      bit_pos = 7'd1;
      fam_disc = '0;
      saved_fam = '0;
      dev = 1'b0;
      saved_dev = 1'b0;
      searching = 1'b0;
      verifying = 1'b0;
      crc = '0;
      dir_taken = 1'b0;
      mismatches = 0;
      accepted = 0;
    endfunction

    function void push_result(orss_pkg::kind_e kind, logic dir, logic fnd, logic fin);
      orss_pkg::res_t r;
      r.out_kind = kind;
      r.direction_bit = dir;
      r.found = fnd;
      r.rom_number = rom;
      r.last = fin;
      results_due.push_back(r);
    endfunction

    function void clear_counts();
      disc = '0;
      dev = 1'b0;
      fam_disc = '0;
    endfunction

    // Closes the search; a verify compares with the saved ROM and restores it.
    function logic finish_search(logic ok);
      logic res;
      res = ok;
      if (res) begin
        disc = zero_pos;
        if (disc == 0) dev = 1'b1;
      end
      if (!res || rom[7:0] == 8'h00) begin
        clear_counts();
        res = 1'b0;
      end
      if (verifying) begin
        res = res && (rom == saved_rom);
        rom = saved_rom;
        disc = saved_disc;
        dev = saved_dev;
        fam_disc = saved_fam;
      end
      searching = 1'b0;
      verifying = 1'b0;
      return res;
    endfunction

    function void begin_search(logic level);
      logic fnd;
      bit_pos = 7'd1;
      zero_pos = '0;
      crc = '0;
      if (dev) begin
        fnd = finish_search(1'b0);
        push_result(orss_pkg::KIND_FIN, 1'b0, fnd, 1'b1);
        return;
      end
      if (!level) begin
        clear_counts();
        fnd = finish_search(1'b0);
        push_result(orss_pkg::KIND_FIN, 1'b0, fnd, 1'b1);
        return;
      end
      searching = 1'b1;
      push_result(orss_pkg::KIND_CMD, 1'b0, 1'b0, 1'b1);
    endfunction

    function void note_request(orss_pkg::req_t q);
      int   idx;
      logic dir, fnd;
      accepted++;
      if (searching) begin
        if (q.req_type != orss_pkg::REQ_BIT) begin
          push_result(orss_pkg::KIND_IGN, 1'b0, 1'b0, 1'b1);
          return;
        end
        if (q.id_bit && q.cmp_bit) begin
          fnd = finish_search(1'b0);
          push_result(orss_pkg::KIND_FIN, 1'b0, fnd, 1'b1);
          return;
        end
        idx = (int'(bit_pos) - 1) & 63;
        if (q.id_bit != q.cmp_bit) begin
          dir = q.id_bit;
        end else begin
          if (bit_pos < disc) dir = rom[idx];
          else dir = (bit_pos == disc);
          if (!dir) begin
            zero_pos = bit_pos;
            if (bit_pos < orss_pkg::FamLimit) fam_disc = bit_pos[3:0];
          end
        end
        rom[idx] = dir;
        dir_taken = dir;
        bit_pos = bit_pos + 7'd1;
        if ((idx & 7) == 7) crc = dallas_crc_step(crc, rom[(idx & 56) +: 8]);
        if (bit_pos >= orss_pkg::RomEnd) begin
          push_result(orss_pkg::KIND_DIR, dir, 1'b0, 1'b0);
          fnd = finish_search(crc == 8'h00);
          push_result(orss_pkg::KIND_FIN, 1'b0, fnd, 1'b1);
        end else begin
          push_result(orss_pkg::KIND_DIR, dir, 1'b0, 1'b1);
        end
        return;
      end
      case (q.req_type)
        orss_pkg::REQ_FIRST: begin
          clear_counts();
          begin_search(q.bus_level);
        end
        orss_pkg::REQ_NEXT: begin
          begin_search(q.bus_level);
        end
        orss_pkg::REQ_VERIFY: begin
          saved_rom = rom;
          saved_disc = disc;
          saved_dev = dev;
          saved_fam = fam_disc;
          disc = orss_pkg::DiscAll;
          dev = 1'b0;
          verifying = 1'b1;
          begin_search(q.bus_level);
        end
        orss_pkg::REQ_TARGET: begin
          rom = {56'd0, q.fam_byte};
          disc = orss_pkg::DiscAll;
          fam_disc = '0;
          dev = 1'b0;
          push_result(orss_pkg::KIND_SETUP, 1'b0, 1'b0, 1'b1);
        end
        orss_pkg::REQ_SKIP: begin
          disc = {3'd0, fam_disc};
          fam_disc = '0;
          if (disc == 0) dev = 1'b1;
          push_result(orss_pkg::KIND_SETUP, 1'b0, 1'b0, 1'b1);
        end
        default: begin
          push_result(orss_pkg::KIND_IGN, 1'b0, 1'b0, 1'b1);
        end
      endcase
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(orss_pkg::res_t got);
      orss_pkg::res_t want;
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
        mismatches++;
        return;
      end
      want = results_due.pop_front();
      compare_field("out_kind", 64'(want.out_kind), 64'(got.out_kind));
      compare_field("direction_bit", 64'(want.direction_bit), 64'(got.direction_bit));
      compare_field("found", 64'(want.found), 64'(got.found));
      compare_field("rom_number", want.rom_number, got.rom_number);
      compare_field("last", 64'(want.last), 64'(got.last));
    endfunction
  endclass

  rom_search_tracker tracker;

  function automatic orss_pkg::req_t make_request(logic [2:0] kind, logic level, logic idb,
                                                  logic cmpb, logic [7:0] fam);
    orss_pkg::req_t q;
    q.req_type = kind;
    q.bus_level = level;
    q.id_bit = idb;
    q.cmp_bit = cmpb;
    q.fam_byte = fam;
    return q;
  endfunction

  function automatic orss_pkg::req_t random_request(logic [2:0] kind);
    return make_request(kind, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
  endfunction

  // A device ROM: family byte, random serial and a CRC byte, spoilt on request.
  function automatic logic [63:0] make_rom(logic [7:0] family, bit spoil);
    logic [63:0] r;
    logic [7:0]  c;
    r = {$urandom, $urandom};
    r[7:0] = family;
    c = 8'h00;
    for (int i = 0; i < 7; i++) begin
      c = dallas_crc_step(c, r[i*8 +: 8]);
    end
    r[63:56] = spoil ? ~c : c;
    return r;
  endfunction

  task automatic send_request(orss_pkg::req_t q);
    int gap;
    if ($urandom_range(0, 39) == 0) in_quiet = !in_quiet;
    gap = in_quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= q;
    do @(posedge clk); while (in_stall);
    tracker.note_request(q);
  endtask

  task automatic issue_command(logic [2:0] kind);
    orss_pkg::req_t q;
    q = random_request(kind);
    q.bus_level = ($urandom_range(0, 15) != 0);
    send_request(q);
  endtask

  // Ends any search left open so that the next command is not ignored.
  task automatic settle();
    if (tracker.searching) begin
      send_request(make_request(orss_pkg::REQ_BIT, 1'b1, 1'b1, 1'b1, 8'h00));
    end
  endtask

  // Answers the bit pairs as the wired-AND of the devices still taking part;
  // at position abort_at the bus reads as if nobody answered.
  task automatic drive_pairs(int abort_at);
    bit   joined[$];
    bit   any0, any1;
    orss_pkg::req_t q;
    joined = {};
    foreach (population[i]) joined.push_back(1'b1);
    for (int n = 0; n < 64 && tracker.searching; n++) begin
      any0 = 1'b0;
      any1 = 1'b0;
      foreach (population[i]) begin
        if (joined[i]) begin
          if (population[i][n]) any1 = 1'b1;
          else any0 = 1'b1;
        end
      end
      q = random_request(orss_pkg::REQ_BIT);
      q.id_bit = !any0;
      q.cmp_bit = !any1;
      if (n == abort_at) begin
        q.id_bit = 1'b1;
        q.cmp_bit = 1'b1;
      end
      send_request(q);
      foreach (population[i]) begin
        if (population[i][n] != tracker.dir_taken) joined[i] = 1'b0;
      end
    end
  endtask

  task automatic fill_population(int count);
    logic [7:0] fam;
    fam = 8'($urandom_range(1, 255));
    population = {};
    for (int k = 0; k < count; k++) begin
      population.push_back(make_rom($urandom_range(0, 1) ? fam : 8'($urandom_range(1, 255)),
                                    1'b0));
    end
  endtask

  task automatic verify_current();
    issue_command(orss_pkg::REQ_VERIFY);
    if (tracker.searching) drive_pairs(64);
  endtask

  task automatic enumerate_devices();
    bit   targeted;
    orss_pkg::req_t q;
    fill_population($urandom_range(1, 4));
    settle();
    targeted = ($urandom_range(0, 3) == 0);
    if (targeted) begin
      q = random_request(orss_pkg::REQ_TARGET);
      q.fam_byte = population[0][7:0];
      send_request(q);
    end
    for (int k = 0; k < 6; k++) begin
      issue_command((k == 0 && !targeted) ? orss_pkg::REQ_FIRST : orss_pkg::REQ_NEXT);
      if (tracker.searching) drive_pairs(64);
      if ($urandom_range(0, 5) == 0) verify_current();
      if ($urandom_range(0, 7) == 0) send_request(random_request(orss_pkg::REQ_SKIP));
      if (tracker.dev && $urandom_range(0, 1)) break;
    end
  endtask

  task automatic search_faulty_device();
    population = {};
    population.push_back(make_rom($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(1, 255)),
                                  1'($urandom_range(0, 1))));
    settle();
    issue_command(orss_pkg::REQ_FIRST);
    if (tracker.searching) drive_pairs(64);
  endtask

  task automatic search_and_verify();
    fill_population($urandom_range(1, 3));
    settle();
    issue_command(orss_pkg::REQ_FIRST);
    if (tracker.searching) drive_pairs(64);
    // Sometimes the found device has left the bus before the verify.
    if ($urandom_range(0, 2) == 0) void'(population.pop_front());
    verify_current();
  endtask

  task automatic broken_search();
    fill_population($urandom_range(1, 3));
    settle();
    issue_command($urandom_range(0, 1) ? orss_pkg::REQ_FIRST : orss_pkg::REQ_NEXT);
    if (tracker.searching) drive_pairs($urandom_range(0, 63));
  endtask

  task automatic send_noise();
    int count;
    count = $urandom_range(3, 15);
    repeat (count) send_request(random_request(3'($urandom_range(0, ReqSpareB))));
  endtask

  task automatic directed_items();
    send_request(make_request(orss_pkg::REQ_BIT, 1'b1, 1'b0, 1'b1, 8'h00));
    send_request(make_request(ReqSpareA, 1'b0, 1'b0, 1'b0, 8'h00));
    send_request(make_request(ReqSpareB, 1'b1, 1'b1, 1'b1, 8'hFF));
    send_request(make_request(orss_pkg::REQ_FIRST, 1'b0, 1'b0, 1'b0, 8'h00));
    send_request(make_request(orss_pkg::REQ_TARGET, 1'b1, 1'b0, 1'b0, 8'hFF));
    send_request(make_request(orss_pkg::REQ_TARGET, 1'b0, 1'b1, 1'b1, 8'h00));
    send_request(make_request(orss_pkg::REQ_SKIP, 1'b0, 1'b0, 1'b0, 8'h00));
    // The skip left no discrepancy, so the next search ends at once.
    send_request(make_request(orss_pkg::REQ_NEXT, 1'b1, 1'b0, 1'b0, 8'h00));
    send_request(make_request(orss_pkg::REQ_FIRST, 1'b1, 1'b0, 1'b0, 8'h00));
    send_request(make_request(orss_pkg::REQ_VERIFY, 1'b1, 1'b0, 1'b0, 8'hFF));
    send_request(make_request(orss_pkg::REQ_BIT, 1'b0, 1'b1, 1'b0, 8'h00));
    send_request(make_request(orss_pkg::REQ_BIT, 1'b0, 1'b0, 1'b1, 8'h00));
    send_request(make_request(orss_pkg::REQ_BIT, 1'b0, 1'b0, 1'b0, 8'h00));
    send_request(make_request(orss_pkg::REQ_BIT, 1'b0, 1'b1, 1'b1, 8'h00));
    send_request(make_request(orss_pkg::REQ_VERIFY, 1'b0, 1'b0, 1'b0, 8'h00));
    send_request(make_request(orss_pkg::REQ_VERIFY, 1'b1, 1'b0, 1'b0, 8'h00));
    send_request(make_request(orss_pkg::REQ_BIT, 1'b1, 1'b1, 1'b1, 8'hFF));
    send_request(make_request(orss_pkg::REQ_SKIP, 1'b1, 1'b1, 1'b1, 8'hFF));
    send_request(make_request(orss_pkg::REQ_NEXT, 1'b1, 1'b1, 1'b1, 8'hFF));
  endtask

  initial begin : stimulus
    int round, pick;
    tracker = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_items();
    round = 0;
    while (tracker.accepted < RandomItems) begin
      case (round)
        0: pick = 0;
        1: pick = 5;
        2: pick = 7;
        3: pick = 6;
        default: pick = $urandom_range(0, 9);
      endcase
      case (pick)
        5: search_faulty_device();
        6: broken_search();
        7: search_and_verify();
        8, 9: send_noise();
        default: enumerate_devices();
      endcase
      round++;
    end
    in_valid <= 1'b0;
    while (tracker.results_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : result_sink
    int gap;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) out_quiet = !out_quiet;
      gap = out_quiet ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      tracker.check_result(out_item);
    end
  end

  initial begin : watchdog
    #8_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
